@@ sv/lrupr_pkg.sv @@
// lrupr_pkg: field widths, reset values and the command/status types of the
// lru page replacement block; shared by the controller, datapath and top level
// no dependencies
package lrupr_pkg;

   localparam int DEF_FRAMES = 8;

   localparam int PAGE_W  = 8;
   localparam int FRAME_W = 3;
   localparam int FAULT_W = 16;
   localparam int CFG_W   = 4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 4'd8;

   // register index, taken from paddr[2]
   localparam logic REG_FRAMES_IN_USE = 1'b0;

   typedef struct packed {
      logic load;
      logic clear;
      logic scan;
      logic touch;
      logic final_wr;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic req_zero;
      logic last;
      logic out_free;
   } status_type;

endpackage

@@ sv/lru_page_replacement.sv @@
// lru_page_replacement: top level of the lru page replacement block with the
// frames_in_use register and its apb-style port
// depends on lrupr_pkg, lrupr_ctrl, lrupr_datapath
//
// usage: a request carries one page number on req_page with req_valid;
// it is taken at a clock edge where req_valid is high and req_stall is low.
// each request gives exactly one result on rsp_hit, rsp_frame,
// rsp_evicted_page and rsp_fault_total, held with rsp_valid until an edge with
// rsp_stall low. from acceptance to the result register a request passes
// through: one read of the frame memory per active frame to scan for hit,
// empty frame and oldest rank, one read-modify-write per active frame to age
// the ranks, one final write, one hand-off. page zero skips both passes and
// the final write. one request is in work at a time; the next is taken as
// soon as the previous result sits in the result register, even while the
// receiver stalls it. a stalled result is held and blocks the next hand-off
// only. reset empties all frames, clears the fault count and sets
// frames_in_use to 8; writing frames_in_use empties all frames and keeps the
// fault count. registers must be written only while idle; the block itself
// does not enforce this.
module lru_page_replacement import lrupr_pkg::*; #(
   parameter int FRAMES = DEF_FRAMES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PAGE_W-1:0]     req_page,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_hit,
   output logic [FRAME_W-1:0]    rsp_frame,
   output logic [PAGE_W-1:0]     rsp_evicted_page,
   output logic [FAULT_W-1:0]    rsp_fault_total,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [CFG_W-1:0] frames_in_use_ff;
   logic             cfg_wr;
   logic             cfg_clear;
   cmd_type          cmd;
   status_type       sts;

   assign pready    = 1'b1;
   assign cfg_wr    = psel && penable && pwrite && pready;
   assign cfg_clear = cfg_wr && (paddr[2] == REG_FRAMES_IN_USE);

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= FRAMES_IN_USE_RST;
      end else if (cfg_clear) begin
         frames_in_use_ff <= pwdata[CFG_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         REG_FRAMES_IN_USE: prdata = CSR_DATA_W'(frames_in_use_ff);
         default:           prdata = '0;
      endcase
   end

   lrupr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lrupr_datapath #(
      .FRAMES (FRAMES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .frames_in_use    (frames_in_use_ff),
      .cfg_clear        (cfg_clear),
      .req_page         (req_page),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_frame        (rsp_frame),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_fault_total  (rsp_fault_total)
   );

endmodule

@@ sv/lrupr_ctrl.sv @@
// lrupr_ctrl: sequencer of the lru page replacement block, steps each request
// through scan, recency update, final write, hand-off (page zero: hand-off)
// depends on lrupr_pkg
module lrupr_ctrl import lrupr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type sts,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TOUCH,
      ST_FINAL,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load  = 1'b1;
               cmd.clear = 1'b1;
               state_in  = sts.req_zero ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.last) begin
               cmd.clear = 1'b1;
               state_in  = ST_TOUCH;
            end
         end
         ST_TOUCH: begin
            cmd.touch = 1'b1;
            if (sts.last) begin
               cmd.clear = 1'b1;
               state_in  = ST_FINAL;
            end
         end
         ST_FINAL: begin
            cmd.final_wr = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ sv/lrupr_datapath.sv @@
// lrupr_datapath: frame memory (page and recency rank), frame valid bits,
// scan and aging logic, fault counter and the result register
// depends on lrupr_pkg
module lrupr_datapath import lrupr_pkg::*; #(
   parameter int FRAMES = DEF_FRAMES
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         sts,
   input  logic [CFG_W-1:0]   frames_in_use,
   input  logic               cfg_clear,
   input  logic [PAGE_W-1:0]  req_page,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_hit,
   output logic [FRAME_W-1:0] rsp_frame,
   output logic [PAGE_W-1:0]  rsp_evicted_page,
   output logic [FAULT_W-1:0] rsp_fault_total
);

   localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W  = $clog2(FRAMES + 1);
   localparam int RANK_W = IDX_W;
   localparam int WORD_W = PAGE_W + RANK_W;

   logic [WORD_W-1:0] mem_ff [FRAMES];
   logic [WORD_W-1:0] rd_data_ff;
   logic [FRAMES-1:0] vld_ff;

   logic [CNT_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  chk_ff;
   logic              chk_vld_ff;

   logic [PAGE_W-1:0] page_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  hit_frame_ff;
   logic [RANK_W-1:0] hit_rank_ff;
   logic              have_empty_ff;
   logic [IDX_W-1:0]  empty_ff;
   logic [IDX_W-1:0]  oldest_ff;
   logic [RANK_W-1:0] oldest_rank_ff;
   logic [PAGE_W-1:0] oldest_page_ff;
   logic [FAULT_W-1:0] fault_ff;

   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic [PAGE_W-1:0]  rsp_evicted_ff;
   logic [FAULT_W-1:0] rsp_fault_ff;

   logic [CNT_W-1:0]  n_act;
   logic              issue;
   logic [PAGE_W-1:0] rd_page;
   logic [RANK_W-1:0] rd_rank;
   logic              rd_occ;
   logic              match;
   logic [IDX_W-1:0]  frame_sel;
   logic [IDX_W+FRAME_W-1:0] frame_wide;
   logic [RANK_W-1:0] limit;
   logic              no_limit;
   logic              age;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [PAGE_W-1:0] evicted;

   assign n_act = (frames_in_use == '0) ? CNT_W'(1) :
                  (32'(frames_in_use) > FRAMES) ? CNT_W'(FRAMES) : CNT_W'(frames_in_use);

   assign issue   = (idx_ff < n_act);
   assign rd_page = rd_data_ff[WORD_W-1:RANK_W];
   assign rd_rank = rd_data_ff[RANK_W-1:0];
   assign rd_occ  = vld_ff[chk_ff];
   assign match   = rd_occ && (rd_page == page_ff);

   assign frame_sel  = found_ff ? hit_frame_ff : (have_empty_ff ? empty_ff : oldest_ff);
   assign frame_wide = {{FRAME_W{1'b0}}, frame_sel};
   assign limit      = found_ff ? hit_rank_ff : oldest_rank_ff;
   assign no_limit   = !found_ff && have_empty_ff;
   assign evicted    = (!found_ff && !have_empty_ff && page_ff != '0) ? oldest_page_ff : '0;

   assign age = cmd.touch && chk_vld_ff && (chk_ff != frame_sel) && rd_occ &&
                (no_limit || rd_rank < limit);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = chk_ff;
      wr_data = {rd_page, rd_rank + RANK_W'(1)};
      if (cmd.final_wr) begin
         wr_en   = 1'b1;
         wr_addr = frame_sel;
         wr_data = {page_ff, {RANK_W{1'b0}}};
      end else if (age) begin
         wr_en = 1'b1;
      end
   end

   assign sts.req_zero = (req_page == '0);
   assign sts.last     = chk_vld_ff && (CNT_W'(chk_ff) == n_act - CNT_W'(1));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // frame memory
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[idx_ff[IDX_W-1:0]];
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         fault_ff     <= '0;
         idx_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cfg_clear) begin
            vld_ff <= '0;
         end else if (cmd.final_wr) begin
            vld_ff[frame_sel] <= 1'b1;
         end
         if (cmd.final_wr && !found_ff && fault_ff != '1) begin
            fault_ff <= fault_ff + FAULT_W'(1);
         end
         if (cmd.clear) begin
            idx_ff     <= '0;
            chk_vld_ff <= 1'b0;
         end else if (cmd.scan || cmd.touch) begin
            chk_vld_ff <= issue;
            if (issue) begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // scan results and result payload
   always_ff @(posedge clock) begin
      if (cmd.scan || cmd.touch) begin
         chk_ff <= idx_ff[IDX_W-1:0];
      end
      if (cmd.load) begin
         page_ff        <= req_page;
         found_ff       <= 1'b0;
         hit_frame_ff   <= '0;
         hit_rank_ff    <= '0;
         have_empty_ff  <= 1'b0;
         empty_ff       <= '0;
         oldest_ff      <= '0;
         oldest_rank_ff <= '0;
         oldest_page_ff <= '0;
      end else if (cmd.scan && chk_vld_ff) begin
         if (match && !found_ff) begin
            found_ff     <= 1'b1;
            hit_frame_ff <= chk_ff;
            hit_rank_ff  <= rd_rank;
         end else if (!rd_occ && !have_empty_ff) begin
            have_empty_ff <= 1'b1;
            empty_ff      <= chk_ff;
         end
         if (rd_occ && rd_rank >= oldest_rank_ff) begin
            oldest_ff      <= chk_ff;
            oldest_rank_ff <= rd_rank;
            oldest_page_ff <= rd_page;
         end
      end
      if (cmd.emit) begin
         rsp_hit_ff     <= found_ff;
         rsp_frame_ff   <= frame_wide[FRAME_W-1:0];
         rsp_evicted_ff <= evicted;
         rsp_fault_ff   <= fault_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_frame        = rsp_frame_ff;
   assign rsp_evicted_page = rsp_evicted_ff;
   assign rsp_fault_total  = rsp_fault_ff;

endmodule
